// ----- hw/rtl/tsfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfe_pkg
// Types, codes and helpers shared by the TPM SPI frame engine.
// ----------------------------------------------------------------------------
package tsfe_pkg;

   localparam int MAX_FRAME = 64;
   localparam int FRAME_W   = 7;
   localparam int PHASE_W   = 2;

   localparam logic [7:0] HDR_READ_FLAG   = 8'h80;
   localparam logic [7:0] HDR_OPCODE      = 8'hD4;
   localparam logic [7:0] RETRY_LIMIT_RST = 8'd50;

   localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
   localparam logic [PHASE_W-1:0] PH_HEADER = 2'd1;
   localparam logic [PHASE_W-1:0] PH_POLL   = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DATA   = 2'd3;

   localparam logic [1:0] ST_RUNNING   = 2'd0;
   localparam logic [1:0] ST_DONE      = 2'd1;
   localparam logic [1:0] ST_TIMEOUT   = 2'd2;
   localparam logic [1:0] ST_IDLE_SLOT = 2'd3;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_SLOT  = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic        is_read;
      logic [15:0] reg_address;
      logic [15:0] total_length;
      logic [7:0]  miso_byte;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] mosi_byte;
      logic       mosi_valid;
      logic [7:0] read_data;
      logic       read_valid;
      logic       write_taken;
      logic       release_cs;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [1:0]         header_index;
      logic [15:0]        bytes_left;
      logic [FRAME_W-1:0] frame_left;
      logic [7:0]         poll_count;
      logic               read_mode;
      logic [15:0]        held_address;
   } state_type;

   function automatic logic [FRAME_W-1:0] frame_size(input logic [15:0] bytes);
      logic [FRAME_W-1:0] res;
      if (bytes < 16'(MAX_FRAME)) begin
         res = bytes[FRAME_W-1:0];
      end else begin
         res = FRAME_W'(MAX_FRAME);
      end
      return res;
   endfunction

   function automatic logic [7:0] header_first(input logic rd,
                                               input logic [FRAME_W-1:0] fl);
      logic [7:0] len_m1;
      len_m1 = {1'b0, fl} - 8'd1;
      return len_m1 | (rd ? HDR_READ_FLAG : 8'h00);
   endfunction

endpackage

// ----- hw/rtl/tsfe_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfe_in_stage
// Input register of the frame engine with valid/stall flow control.
// ----------------------------------------------------------------------------
module tsfe_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  tsfe_pkg::req_type req_item,
   output logic             req_stall,
   input  logic             advance,
   output logic             in_valid,
   output tsfe_pkg::req_type in_item
);

   logic             valid_ff;
   logic             valid_in;
   tsfe_pkg::req_type item_ff;
   logic             load;

   assign load      = req_valid && (!valid_ff || advance);
   assign req_stall = valid_ff && !advance;
   assign valid_in  = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign in_valid = valid_ff;
   assign in_item  = item_ff;

endmodule

// ----- hw/rtl/tsfe_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfe_step
// Next phase and slot result for one transaction of the frame engine.
// ----------------------------------------------------------------------------
module tsfe_step (
   input  tsfe_pkg::req_type   item,
   input  tsfe_pkg::state_type cur,
   input  logic [7:0]          retry_limit,
   output tsfe_pkg::state_type nxt,
   output tsfe_pkg::rsp_type   rsp
);

   logic                         do_finish;
   logic [1:0]                   fin_status;
   logic                         do_begin;
   logic [15:0]                  begin_bytes;
   logic                         do_data;
   logic                         do_poll;
   logic [7:0]                   poll_val;
   logic [1:0]                   hi_next;
   logic [tsfe_pkg::FRAME_W-1:0] fl_dec;
   logic [15:0]                  bl_dec;
   logic [7:0]                   pc_inc;
   logic [tsfe_pkg::FRAME_W-1:0] fl_new;

   assign hi_next = cur.header_index + 2'd1;
   assign fl_dec  = (cur.frame_left != '0) ? cur.frame_left - 1'b1 : cur.frame_left;
   assign bl_dec  = (cur.bytes_left != '0) ? cur.bytes_left - 16'd1 : cur.bytes_left;
   assign pc_inc  = (cur.poll_count != 8'hFF) ? cur.poll_count + 8'd1 : cur.poll_count;

   always_comb begin
      nxt         = cur;
      rsp         = '0;
      do_finish   = 1'b0;
      fin_status  = tsfe_pkg::ST_DONE;
      do_begin    = 1'b0;
      begin_bytes = cur.bytes_left;
      do_data     = 1'b0;
      do_poll     = 1'b0;
      poll_val    = cur.poll_count;
      fl_new      = '0;

      case (item.cmd)
         tsfe_pkg::CMD_START: begin
            nxt.read_mode    = item.is_read;
            nxt.held_address = item.reg_address;
            nxt.bytes_left   = item.total_length;
            nxt.poll_count   = 8'd0;
            begin_bytes      = item.total_length;
            if (item.total_length == 16'd0) begin
               do_finish = 1'b1;
            end else begin
               do_begin = 1'b1;
            end
         end
         default: begin
            unique case (cur.phase)
               tsfe_pkg::PH_HEADER: begin
                  if (cur.header_index != 2'd3) begin
                     nxt.header_index = hi_next;
                     rsp.mosi_valid   = 1'b1;
                     unique case (hi_next)
                        2'd1:    rsp.mosi_byte = tsfe_pkg::HDR_OPCODE;
                        2'd2:    rsp.mosi_byte = cur.held_address[15:8];
                        default: rsp.mosi_byte = cur.held_address[7:0];
                     endcase
                  end else if (item.miso_byte[0]) begin
                     do_data = 1'b1;
                  end else begin
                     poll_val       = 8'd0;
                     nxt.poll_count = 8'd0;
                     do_poll        = 1'b1;
                  end
               end
               tsfe_pkg::PH_POLL: begin
                  poll_val       = pc_inc;
                  nxt.poll_count = pc_inc;
                  if (item.miso_byte[0]) begin
                     do_data = 1'b1;
                  end else begin
                     do_poll = 1'b1;
                  end
               end
               tsfe_pkg::PH_DATA: begin
                  if (cur.read_mode) begin
                     rsp.read_data  = item.miso_byte;
                     rsp.read_valid = 1'b1;
                  end
                  nxt.frame_left = fl_dec;
                  nxt.bytes_left = bl_dec;
                  begin_bytes    = bl_dec;
                  if ((fl_dec != '0) && (bl_dec != 16'd0)) begin
                     do_data = 1'b1;
                  end else if (bl_dec != 16'd0) begin
                     do_begin = 1'b1;
                  end else begin
                     do_finish = 1'b1;
                  end
               end
               default: begin
                  nxt.phase  = tsfe_pkg::PH_IDLE;
                  rsp.status = tsfe_pkg::ST_IDLE_SLOT;
               end
            endcase
         end
      endcase

      if (do_poll) begin
         if (poll_val >= retry_limit) begin
            do_finish  = 1'b1;
            fin_status = tsfe_pkg::ST_TIMEOUT;
         end else begin
            nxt.phase      = tsfe_pkg::PH_POLL;
            rsp.mosi_byte  = 8'h00;
            rsp.mosi_valid = 1'b1;
         end
      end

      if (do_data) begin
         nxt.phase      = tsfe_pkg::PH_DATA;
         rsp.mosi_valid = 1'b1;
         if (!nxt.read_mode) begin
            rsp.mosi_byte   = item.write_byte;
            rsp.write_taken = 1'b1;
         end
      end

      if (do_begin) begin
         fl_new           = tsfe_pkg::frame_size(begin_bytes);
         nxt.frame_left   = fl_new;
         nxt.header_index = 2'd0;
         nxt.phase        = tsfe_pkg::PH_HEADER;
         rsp.mosi_byte    = tsfe_pkg::header_first(nxt.read_mode, fl_new);
         rsp.mosi_valid   = 1'b1;
      end

      if (do_finish) begin
         nxt.phase        = tsfe_pkg::PH_IDLE;
         nxt.header_index = 2'd0;
         nxt.frame_left   = '0;
         nxt.bytes_left   = 16'd0;
         nxt.poll_count   = 8'd0;
         rsp.release_cs   = 1'b1;
         rsp.status       = fin_status;
      end
   end

endmodule

// ----- hw/rtl/tpm_spi_frame_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_spi_frame_engine_unit
// Host side of TPM register transactions over SPI: header, wait-state
// polling and data slots, framed at up to 64 bytes.
//
//   channel  | direction | handshake          | carries
//   req_*    | in        | req_valid/req_stall| start or completed slot
//   rsp_*    | out       | rsp_valid/rsp_stall| next slot, read data, status
//   csr_*    | in        | csr_wr_en          | retry_limit
//
// One transaction per cycle while rsp_stall is not holding the result
// register; path: input register, single next-phase step, result register.
// Synchronous reset clears phase, counters and retry_limit to 50.
// rsp_stall holds both stages; req_stall rises while the input register is
// full and the result register is stalled.
// ----------------------------------------------------------------------------
module tpm_spi_frame_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic        req_is_read,
   input  logic [15:0] req_reg_address,
   input  logic [15:0] req_total_length,
   input  logic [7:0]  req_miso_byte,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_mosi_byte,
   output logic        rsp_mosi_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_read_valid,
   output logic        rsp_write_taken,
   output logic        rsp_release_cs,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   tsfe_pkg::req_type   req_item;
   tsfe_pkg::req_type   in_item;
   logic                in_valid;
   logic                advance;
   tsfe_pkg::state_type state_ff;
   tsfe_pkg::state_type state_in;
   tsfe_pkg::rsp_type   rsp_ff;
   tsfe_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [7:0]          retry_limit_ff;
   logic                fire;

   assign req_item = '{cmd:          req_cmd,
                       is_read:      req_is_read,
                       reg_address:  req_reg_address,
                       total_length: req_total_length,
                       miso_byte:    req_miso_byte,
                       write_byte:   req_write_byte};

   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign fire         = in_valid && advance;
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   tsfe_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_item   (in_item)
   );

   tsfe_step u_step (
      .item        (in_item),
      .cur         (state_ff),
      .retry_limit (retry_limit_ff),
      .nxt         (state_in),
      .rsp         (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         retry_limit_ff <= tsfe_pkg::RETRY_LIMIT_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            retry_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mosi_byte   = rsp_ff.mosi_byte;
   assign rsp_mosi_valid  = rsp_ff.mosi_valid;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_read_valid  = rsp_ff.read_valid;
   assign rsp_write_taken = rsp_ff.write_taken;
   assign rsp_release_cs  = rsp_ff.release_cs;
   assign rsp_status      = rsp_ff.status;

`ifndef SYNTHESIS
   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_release_cs |-> state_ff.phase == tsfe_pkg::PH_IDLE)
      else $error("release_cs without idle phase");

   a_read_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> state_ff.read_mode)
      else $error("read data in write transfer");

   a_taken_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_taken |-> state_ff.phase == tsfe_pkg::PH_DATA
                                       && !state_ff.read_mode)
      else $error("write byte taken outside write data phase");

   a_frame_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == tsfe_pkg::PH_HEADER |-> state_ff.frame_left != '0)
      else $error("header with empty frame");
`endif

endmodule

// ----- test/tpm_spi_frame_engine_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_spi_frame_engine_unit_tb
// Self-checking bench for the TPM SPI frame engine. A cycle-free predictor
// tracks header, wait-state poll and data phases and queues the expected
// response for every request transaction. The sender runs in random bursts
// and the receiver stalls on its own pattern. Directed cases cover idle
// slots, zero length, polling, zero retry limit and start while busy. The
// random phases sweep the retry limit and frame sizes.
// ----------------------------------------------------------------------------
module tpm_spi_frame_engine_unit_tb;

   localparam int LIMIT_NS = 1_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = 1'b0;
   logic        req_is_read = 1'b0;
   logic [15:0] req_reg_address = '0;
   logic [15:0] req_total_length = '0;
   logic [7:0]  req_miso_byte = '0;
   logic [7:0]  req_write_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_mosi_byte;
   logic        rsp_mosi_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_read_valid;
   logic        rsp_write_taken;
   logic        rsp_release_cs;
   logic [1:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   tpm_spi_frame_engine_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_is_read      (req_is_read),
      .req_reg_address  (req_reg_address),
      .req_total_length (req_total_length),
      .req_miso_byte    (req_miso_byte),
      .req_write_byte   (req_write_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mosi_byte    (rsp_mosi_byte),
      .rsp_mosi_valid   (rsp_mosi_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_write_taken  (rsp_write_taken),
      .rsp_release_cs   (rsp_release_cs),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #1 clock = ~clock;

   // predicted engine state
   logic [tsfe_pkg::PHASE_W-1:0] eng_phase;
   logic [1:0]                   eng_hdr_idx;
   logic [15:0]                  eng_bytes_left;
   logic [tsfe_pkg::FRAME_W-1:0] eng_frame_left;
   logic [7:0]                   eng_poll_count;
   logic                         eng_read_mode;
   logic [15:0]                  eng_address;
   logic [7:0]                   eng_retry_limit;

   tsfe_pkg::rsp_type pred_rsp;
   tsfe_pkg::rsp_type exp_rsp_q[$];
   tsfe_pkg::rsp_type got_rsp;
   tsfe_pkg::rsp_type want_rsp;

   int err_count = 0;
   int items_sent = 0;
   int burst_left = 0;
   int stall_run = 0;
   int stall_mode = 0;

   // -------------------------------------------------------------------------
   // predictor
   // -------------------------------------------------------------------------
   function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = ({1'b0, eng_frame_left} - 8'd1) |
                   (eng_read_mode ? tsfe_pkg::HDR_READ_FLAG : 8'h00);
         2'd1: b = tsfe_pkg::HDR_OPCODE;
         2'd2: b = eng_address[15:8];
         default: b = eng_address[7:0];
      endcase
      return b;
   endfunction

   function automatic void open_frame();
      if (eng_bytes_left < 16'(tsfe_pkg::MAX_FRAME)) begin
         eng_frame_left = eng_bytes_left[tsfe_pkg::FRAME_W-1:0];
      end else begin
         eng_frame_left = tsfe_pkg::FRAME_W'(tsfe_pkg::MAX_FRAME);
      end
      eng_hdr_idx = 2'd0;
      eng_phase = tsfe_pkg::PH_HEADER;
      pred_rsp.mosi_byte = hdr_byte(2'd0);
      pred_rsp.mosi_valid = 1'b1;
   endfunction

   function automatic void data_slot(input logic [7:0] wbyte);
      eng_phase = tsfe_pkg::PH_DATA;
      if (eng_read_mode) begin
         pred_rsp.mosi_byte = 8'h00;
      end else begin
         pred_rsp.mosi_byte = wbyte;
         pred_rsp.write_taken = 1'b1;
      end
      pred_rsp.mosi_valid = 1'b1;
   endfunction

   function automatic void close_transfer(input logic [1:0] st);
      eng_phase = tsfe_pkg::PH_IDLE;
      eng_hdr_idx = 2'd0;
      eng_frame_left = '0;
      eng_bytes_left = '0;
      eng_poll_count = '0;
      pred_rsp.release_cs = 1'b1;
      pred_rsp.status = st;
   endfunction

   function automatic void poll_or_timeout();
      if (eng_poll_count >= eng_retry_limit) begin
         close_transfer(tsfe_pkg::ST_TIMEOUT);
      end else begin
         eng_phase = tsfe_pkg::PH_POLL;
         pred_rsp.mosi_byte = 8'h00;
         pred_rsp.mosi_valid = 1'b1;
      end
   endfunction

   function automatic void predict_slot_rsp(input tsfe_pkg::req_type r);
      pred_rsp = '0;
      pred_rsp.status = tsfe_pkg::ST_RUNNING;
      if (r.cmd == tsfe_pkg::CMD_START) begin
         eng_read_mode = r.is_read;
         eng_address = r.reg_address;
         eng_bytes_left = r.total_length;
         eng_poll_count = '0;
         if (eng_bytes_left == 16'd0) begin
            close_transfer(tsfe_pkg::ST_DONE);
         end else begin
            open_frame();
         end
         return;
      end
      case (eng_phase)
         tsfe_pkg::PH_HEADER: begin
            if (eng_hdr_idx != 2'd3) begin
               eng_hdr_idx = eng_hdr_idx + 2'd1;
               pred_rsp.mosi_byte = hdr_byte(eng_hdr_idx);
               pred_rsp.mosi_valid = 1'b1;
            end else if (r.miso_byte[0]) begin
               data_slot(r.write_byte);
            end else begin
               eng_poll_count = '0;
               poll_or_timeout();
            end
         end
         tsfe_pkg::PH_POLL: begin
            if (eng_poll_count != 8'hFF) eng_poll_count = eng_poll_count + 8'd1;
            if (r.miso_byte[0]) begin
               data_slot(r.write_byte);
            end else begin
               poll_or_timeout();
            end
         end
         tsfe_pkg::PH_DATA: begin
            if (eng_read_mode) begin
               pred_rsp.read_data = r.miso_byte;
               pred_rsp.read_valid = 1'b1;
            end
            if (eng_frame_left != '0) eng_frame_left = eng_frame_left - 1'b1;
            if (eng_bytes_left != '0) eng_bytes_left = eng_bytes_left - 16'd1;
            if (eng_frame_left != '0 && eng_bytes_left != '0) begin
               data_slot(r.write_byte);
            end else if (eng_bytes_left != '0) begin
               open_frame();
            end else begin
               close_transfer(tsfe_pkg::ST_DONE);
            end
         end
         default: begin
            eng_phase = tsfe_pkg::PH_IDLE;
            pred_rsp.status = tsfe_pkg::ST_IDLE_SLOT;
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // driver
   // -------------------------------------------------------------------------
   task automatic send_req(input tsfe_pkg::req_type r);
      int gap;
      predict_slot_rsp(r);
      exp_rsp_q.push_back(pred_rsp);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
         burst_left = int'($urandom_range(1, 16));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_cmd          <= r.cmd;
      req_is_read      <= r.is_read;
      req_reg_address  <= r.reg_address;
      req_total_length <= r.total_length;
      req_miso_byte    <= r.miso_byte;
      req_write_byte   <= r.write_byte;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain_rsp();
      req_valid <= 1'b0;
      wait (exp_rsp_q.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_retry_limit(input logic [7:0] lim);
      drain_rsp();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 8'($urandom_range(0, 255));
      eng_retry_limit = lim;
   endtask

   task automatic send_idle_slot(input logic [7:0] miso, input logic [7:0] wbyte);
      tsfe_pkg::req_type r;
      r.cmd          = tsfe_pkg::CMD_SLOT;
      r.is_read      = 1'($urandom_range(0, 1));
      r.reg_address  = 16'($urandom_range(0, 65535));
      r.total_length = 16'($urandom_range(0, 65535));
      r.miso_byte    = miso;
      r.write_byte   = wbyte;
      send_req(r);
   endtask

   // One transfer: start, then slots until release or max_slots. Each frame
   // sees wait_polls clear wait bits before a set one.
   task automatic run_transfer(input logic rd, input logic [15:0] addr,
                               input logic [15:0] len, input int wait_polls,
                               input int max_slots);
      tsfe_pkg::req_type r;
      int slots;
      int waits;
      slots = 0;
      waits = 0;
      r.cmd          = tsfe_pkg::CMD_START;
      r.is_read      = rd;
      r.reg_address  = addr;
      r.total_length = len;
      r.miso_byte    = 8'($urandom_range(0, 255));
      r.write_byte   = 8'($urandom_range(0, 255));
      send_req(r);
      while (eng_phase != tsfe_pkg::PH_IDLE && slots < max_slots) begin
         r.cmd          = tsfe_pkg::CMD_SLOT;
         r.is_read      = 1'($urandom_range(0, 1));
         r.reg_address  = 16'($urandom_range(0, 65535));
         r.total_length = 16'($urandom_range(0, 65535));
         r.miso_byte    = 8'($urandom_range(0, 255));
         r.write_byte   = 8'($urandom_range(0, 255));
         if (eng_phase == tsfe_pkg::PH_HEADER && eng_hdr_idx == 2'd0) waits = 0;
         if ((eng_phase == tsfe_pkg::PH_HEADER && eng_hdr_idx == 2'd3) ||
             eng_phase == tsfe_pkg::PH_POLL) begin
            r.miso_byte[0] = (waits >= wait_polls);
            waits++;
         end
         send_req(r);
         slots++;
      end
   endtask

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   task automatic test_idle_slot();
      send_idle_slot(8'hFF, 8'hFF);
   endtask

   task automatic test_zero_length();
      run_transfer(1'b0, 16'hFFFF, 16'h0000, 0, 0);
      run_transfer(1'b1, 16'h0000, 16'h0000, 0, 0);
   endtask

   task automatic test_read_frame();
      run_transfer(1'b1, 16'hFFFF, 16'd1, 0, 1000);
   endtask

   task automatic test_write_polls();
      write_retry_limit(8'd3);
      run_transfer(1'b0, 16'h0000, 16'd1, 2, 1000);
   endtask

   task automatic test_zero_retry_timeout();
      write_retry_limit(8'd0);
      run_transfer(1'b0, 16'h5AA5, 16'd5, 1, 1000);
   endtask

   task automatic test_start_while_busy();
      write_retry_limit(8'd50);
      run_transfer(1'b1, 16'h8001, 16'hFFFF, 0, 2);
      run_transfer(1'b0, 16'h7FFE, 16'h0000, 0, 0);
   endtask

   task automatic test_random(input logic [7:0] lim, input int n_items);
      int stop_at;
      int sel;
      int waitp;
      int cap;
      logic [15:0] len;
      write_retry_limit(lim);
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         sel = int'($urandom_range(0, 99));
         cap = 1_000_000;
         if (sel < 65) begin
            len = 16'($urandom_range(1, 8));
         end else if (sel < 82) begin
            len = 16'($urandom_range(9, 140));
         end else if (sel < 87) begin
            len = 16'd0;
         end else begin
            len = 16'($urandom_range(0, 65535));
            cap = int'($urandom_range(1, 40));
         end
         if ($urandom_range(0, 19) == 0) cap = int'($urandom_range(0, 10));
         sel = int'($urandom_range(0, 9));
         if (sel < 6) begin
            waitp = 0;
         end else if (sel < 9) begin
            waitp = int'($urandom_range(1, 4));
         end else begin
            waitp = int'($urandom_range(0, (lim < 8) ? int'(lim) + 2 : 6));
         end
         run_transfer(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), len,
                      waitp, cap);
         if ($urandom_range(0, 9) == 0) begin
            send_idle_slot(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // receiver stall pattern
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_run  <= 0;
         stall_mode <= 0;
      end else begin
         if (stall_run == 0) begin
            stall_mode <= int'($urandom_range(0, 2));
            stall_run  <= int'($urandom_range(4, 40));
         end else begin
            stall_run <= stall_run - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // response checker
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $time);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rsp.mosi_byte   = rsp_mosi_byte;
         got_rsp.mosi_valid  = rsp_mosi_valid;
         got_rsp.read_data   = rsp_read_data;
         got_rsp.read_valid  = rsp_read_valid;
         got_rsp.write_taken = rsp_write_taken;
         got_rsp.release_cs  = rsp_release_cs;
         got_rsp.status      = rsp_status;
         if (exp_rsp_q.size() == 0) begin
            report_mismatch("unexpected transaction", int'(got_rsp), 0);
         end else begin
            want_rsp = exp_rsp_q.pop_front();
            if (got_rsp.mosi_byte !== want_rsp.mosi_byte)
               report_mismatch("mosi_byte", int'(got_rsp.mosi_byte),
                               int'(want_rsp.mosi_byte));
            if (got_rsp.mosi_valid !== want_rsp.mosi_valid)
               report_mismatch("mosi_valid", int'(got_rsp.mosi_valid),
                               int'(want_rsp.mosi_valid));
            if (got_rsp.read_data !== want_rsp.read_data)
               report_mismatch("read_data", int'(got_rsp.read_data),
                               int'(want_rsp.read_data));
            if (got_rsp.read_valid !== want_rsp.read_valid)
               report_mismatch("read_valid", int'(got_rsp.read_valid),
                               int'(want_rsp.read_valid));
            if (got_rsp.write_taken !== want_rsp.write_taken)
               report_mismatch("write_taken", int'(got_rsp.write_taken),
                               int'(want_rsp.write_taken));
            if (got_rsp.release_cs !== want_rsp.release_cs)
               report_mismatch("release_cs", int'(got_rsp.release_cs),
                               int'(want_rsp.release_cs));
            if (got_rsp.status !== want_rsp.status)
               report_mismatch("status", int'(got_rsp.status), int'(want_rsp.status));
         end
      end
   end

   // -------------------------------------------------------------------------
   // sequence
   // -------------------------------------------------------------------------
   initial begin
      eng_phase       = tsfe_pkg::PH_IDLE;
      eng_hdr_idx     = '0;
      eng_bytes_left  = '0;
      eng_frame_left  = '0;
      eng_poll_count  = '0;
      eng_read_mode   = 1'b0;
      eng_address     = '0;
      eng_retry_limit = tsfe_pkg::RETRY_LIMIT_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_slot();
      test_zero_length();
      test_read_frame();
      test_write_polls();
      test_zero_retry_timeout();
      test_start_while_busy();

      test_random(8'd255, 50);
      test_random(8'd0, 50);
      test_random(8'd1, 50);
      test_random(8'd50, 50);
      test_random(8'($urandom_range(2, 254)), 50);
      test_random(8'd4, 50);

      drain_rsp();
      repeat (8) @(posedge clock);
      if (err_count == 0 && exp_rsp_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- tpm_spi_frame_engine_unit.f -----
hw/rtl/tsfe_pkg.sv
hw/rtl/tsfe_in_stage.sv
hw/rtl/tsfe_step.sv
hw/rtl/tpm_spi_frame_engine_unit.sv
test/tpm_spi_frame_engine_unit_tb.sv
